// ===== src/crc8rfp_pkg.sv =====
package crc8rfp_pkg;

  typedef enum logic [2:0] {
    PH_SYNC    = 3'd0,
    PH_STATUS  = 3'd1,
    PH_LEN_HI  = 3'd2,
    PH_LEN_LO  = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CHECK   = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    EV_HEADER   = 3'd0,
    EV_KEPT     = 3'd1,
    EV_DROPPED  = 3'd2,
    EV_GOOD     = 3'd3,
    EV_BAD_SYNC = 3'd4,
    EV_BAD_CRC  = 3'd5
  } event_e;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] REG_SYNC_VALUE = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_OK_CODE    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_CRC_POLY   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_CRC_SEED   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_KEEP_LIMIT = 3'd4;

  localparam logic [7:0] CRC_POLY_RESET = 8'h07;

  // msb-first crc-8 over one byte, unreflected
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] data,
                                           input logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ poly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== src/crc8_response_frame_parser.sv =====
// Response frame parser: takes one received byte per word on the input channel and gives
// exactly one result word per byte (header byte, payload kept or dropped, frame good, bad
// sync or crc mismatch). A frame is sync byte, status code, 16-bit big-endian length,
// payload and a crc-8 check byte; the crc (msb first, no final xor) starts from crc_seed at
// the sync byte. One byte is accepted every cycle unless the input is stalled; a byte sits
// in the input register and its result is then registered in the result register.
// The input stalls only while both the input register and the result register are full and
// the output is stalled. Configuration writes are always ready and belong to idle periods.
module crc8_response_frame_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  event_res_o,
  output logic [7:0]  payload_byte_o,
  output logic [15:0] payload_index_o,
  output logic [7:0]  status_byte_o,
  output logic        status_bad_o,
  output logic [15:0] kept_count_o,
  output logic        frame_end_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [crc8rfp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic [7:0]  sync_value_q, ok_code_q, crc_poly_q, crc_seed_q;
  logic [15:0] keep_limit_q;

  logic        in_valid_q;
  logic [7:0]  byte_q;
  logic        out_adv;
  logic        advance;

  crc8rfp_pkg::phase_e phase_q, phase_d;
  logic [7:0]  crc_q, crc_d;
  logic [15:0] length_q, length_d;
  logic [15:0] count_q, count_d;
  logic [7:0]  status_q, status_d;
  logic [15:0] kept_q, kept_d;

  logic        out_valid_q;
  crc8rfp_pkg::event_e event_q, event_d;
  logic [7:0]  pbyte_q, pbyte_d;
  logic [15:0] pidx_q, pidx_d;
  logic [7:0]  sbyte_q, sbyte_d;
  logic        sbad_q, sbad_d;
  logic        fend_q, fend_d;
  logic [15:0] kept_out_q;
  logic        have_status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_value_q <= 8'd0;
      ok_code_q    <= 8'd0;
      crc_poly_q   <= crc8rfp_pkg::CRC_POLY_RESET;
      crc_seed_q   <= 8'd0;
      keep_limit_q <= 16'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        crc8rfp_pkg::REG_SYNC_VALUE: sync_value_q <= cfg_data_i[7:0];
        crc8rfp_pkg::REG_OK_CODE:    ok_code_q    <= cfg_data_i[7:0];
        crc8rfp_pkg::REG_CRC_POLY:   crc_poly_q   <= cfg_data_i[7:0];
        crc8rfp_pkg::REG_CRC_SEED:   crc_seed_q   <= cfg_data_i[7:0];
        crc8rfp_pkg::REG_KEEP_LIMIT: keep_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  assign out_adv    = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_adv;
  assign in_stall_o = in_valid_q && !out_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= rx_byte_i;
    end
  end

  // frame state and result
  always_comb begin
    phase_d     = phase_q;
    crc_d       = crc_q;
    length_d    = length_q;
    count_d     = count_q;
    status_d    = status_q;
    kept_d      = kept_q;
    event_d     = crc8rfp_pkg::EV_HEADER;
    pbyte_d     = 8'd0;
    pidx_d      = 16'd0;
    fend_d      = 1'b0;
    have_status = 1'b1;
    unique case (phase_q)
      crc8rfp_pkg::PH_STATUS: begin
        status_d = byte_q;
        crc_d    = crc8rfp_pkg::crc8_feed(crc_q, byte_q, crc_poly_q);
        phase_d  = crc8rfp_pkg::PH_LEN_HI;
      end
      crc8rfp_pkg::PH_LEN_HI: begin
        length_d = {byte_q, 8'd0};
        crc_d    = crc8rfp_pkg::crc8_feed(crc_q, byte_q, crc_poly_q);
        phase_d  = crc8rfp_pkg::PH_LEN_LO;
      end
      crc8rfp_pkg::PH_LEN_LO: begin
        length_d = {length_q[15:8], byte_q};
        crc_d    = crc8rfp_pkg::crc8_feed(crc_q, byte_q, crc_poly_q);
        count_d  = 16'd0;
        phase_d  = (length_d == 16'd0) ? crc8rfp_pkg::PH_CHECK : crc8rfp_pkg::PH_PAYLOAD;
      end
      crc8rfp_pkg::PH_PAYLOAD: begin
        crc_d  = crc8rfp_pkg::crc8_feed(crc_q, byte_q, crc_poly_q);
        pidx_d = count_q;
        if (count_q < keep_limit_q) begin
          event_d = crc8rfp_pkg::EV_KEPT;
          pbyte_d = byte_q;
          kept_d  = kept_q + 16'd1;
        end else begin
          event_d = crc8rfp_pkg::EV_DROPPED;
        end
        count_d = count_q + 16'd1;
        if (count_d == length_q) begin
          phase_d = crc8rfp_pkg::PH_CHECK;
        end
      end
      crc8rfp_pkg::PH_CHECK: begin
        event_d = (byte_q == crc_q) ? crc8rfp_pkg::EV_GOOD : crc8rfp_pkg::EV_BAD_CRC;
        fend_d  = 1'b1;
        phase_d = crc8rfp_pkg::PH_SYNC;
      end
      default: begin
        have_status = 1'b0;
        length_d    = 16'd0;
        count_d     = 16'd0;
        status_d    = 8'd0;
        kept_d      = 16'd0;
        if (byte_q == sync_value_q) begin
          crc_d   = crc8rfp_pkg::crc8_feed(crc_seed_q, byte_q, crc_poly_q);
          phase_d = crc8rfp_pkg::PH_STATUS;
        end else begin
          crc_d   = crc_seed_q;
          event_d = crc8rfp_pkg::EV_BAD_SYNC;
          fend_d  = 1'b1;
          phase_d = crc8rfp_pkg::PH_SYNC;
        end
      end
    endcase
    sbyte_d = have_status ? status_d : 8'd0;
    sbad_d  = have_status && (status_d != ok_code_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= crc8rfp_pkg::PH_SYNC;
      crc_q    <= 8'd0;
      length_q <= 16'd0;
      count_q  <= 16'd0;
      status_q <= 8'd0;
      kept_q   <= 16'd0;
    end else if (advance) begin
      phase_q  <= phase_d;
      crc_q    <= crc_d;
      length_q <= length_d;
      count_q  <= count_d;
      status_q <= status_d;
      kept_q   <= kept_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      event_q    <= event_d;
      pbyte_q    <= pbyte_d;
      pidx_q     <= pidx_d;
      sbyte_q    <= sbyte_d;
      sbad_q     <= sbad_d;
      fend_q     <= fend_d;
      kept_out_q <= kept_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_res_o     = event_q;
  assign payload_byte_o  = pbyte_q;
  assign payload_index_o = pidx_q;
  assign status_byte_o   = sbyte_q;
  assign status_bad_o    = sbad_q;
  assign kept_count_o    = kept_out_q;
  assign frame_end_o     = fend_q;

`ifndef NO_ASSERTIONS
  a_fend_matches_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (fend_q == (event_q == crc8rfp_pkg::EV_GOOD ||
                                event_q == crc8rfp_pkg::EV_BAD_SYNC ||
                                event_q == crc8rfp_pkg::EV_BAD_CRC)))
    else $error("frame_end disagrees with event");

  a_phase_holds_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> $stable(phase_q))
    else $error("frame state moved while result stalled");

  a_kept_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && event_q == crc8rfp_pkg::EV_KEPT) |-> (kept_out_q != 16'd0))
    else $error("kept word without kept count");

  a_bad_sync_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && event_q == crc8rfp_pkg::EV_BAD_SYNC) |->
      (!sbad_q && sbyte_q == 8'd0 && kept_out_q == 16'd0))
    else $error("bad sync result carries frame state");
`endif

endmodule
